// ----- sv/csvip_pkg.sv -----
// Package for the CSV integer field parser: character codes, field state type, per-byte conversion.
package csvip_pkg;

	localparam logic [7:0] CH_QUOTE = 8'd34;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_PLUS  = 8'd43;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;
	localparam logic [7:0] DELIM_RESET = 8'd44;

	typedef enum logic [1:0] {
		PH_LEAD   = 2'd0,
		PH_SIGN   = 2'd1,
		PH_DIGITS = 2'd2,
		PH_DONE   = 2'd3
	} phase_t;

	typedef struct packed {
		phase_t      phase;
		logic        neg;
		logic [31:0] acc;
		logic        ovf;
	} field_t;

	localparam field_t FIELD_CLEAR = '{phase: PH_LEAD, neg: 1'b0, acc: 32'd0, ovf: 1'b0};

	// strtoul-style step: whitespace, sign, digits, then stop
	function automatic field_t feed_char(field_t f, logic [7:0] c);
		logic        digit;
		logic        space;
		logic [35:0] nxt;
		field_t      r;
		r     = f;
		digit = (c >= CH_ZERO) && (c <= CH_NINE);
		space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
		nxt   = ({4'd0, f.acc} << 3) + ({4'd0, f.acc} << 1) + {28'd0, c - CH_ZERO};
		if (f.phase == PH_LEAD && space) begin
			r = f;
		end else if (f.phase == PH_LEAD && (c == CH_PLUS || c == CH_MINUS)) begin
			r.neg   = (c == CH_MINUS);
			r.phase = PH_SIGN;
		end else if (f.phase != PH_DONE && digit) begin
			if (nxt[35:32] != 4'd0) begin
				r.ovf = 1'b1;
			end
			r.acc   = nxt[31:0];
			r.phase = PH_DIGITS;
		end else begin
			r.phase = PH_DONE;
		end
		return r;
	endfunction

	function automatic logic [31:0] field_result(field_t f);
		logic [31:0] r;
		if (f.ovf) begin
			r = 32'hFFFF_FFFF;
		end else if (f.neg) begin
			r = 32'd0 - f.acc;
		end else begin
			r = f.acc;
		end
		return r;
	endfunction

endpackage

// ----- sv/csv_integer_field_parser.sv -----
// CSV integer field parser: byte-wise quote/delimiter/row handling and decimal field conversion.
//
// One byte of CSV text enters per item and the block sustains one item per
// clock cycle while in_ready is high. An item is held in an input register,
// where one stage of logic updates the quote and row state and the running
// decimal value and builds at most one result; that result is held in the
// output register. The rate is set by that single per-byte state update (a
// 36-bit multiply-by-ten add). in_ready drops only while a byte that makes
// a result waits behind a result not yet taken. Each delimiter gives one
// field, CR or LF gives the last field of a row (an LF right after it is
// dropped), and end_of_input gives one result with field_present low and
// row_end high and resets the parse state. delimiter_char resets to a comma
// and is written through the cfg channel; the user must write it only while
// the block is idle, which the block itself does not enforce.
module csv_integer_field_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         delimiter_char,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         data_byte,
	input  logic               end_of_input,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] field_value,
	output logic               field_present,
	output logic               row_end
);

	logic [7:0]  delim_q;
	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        eoi_s1;

	logic                 in_quotes_q;
	logic                 quote_pending_q;
	logic                 swallow_lf_q;
	csvip_pkg::field_t    field_q;

	logic                 in_quotes_d;
	logic                 quote_pending_d;
	logic                 swallow_lf_d;
	csvip_pkg::field_t    field_d;

	logic        res_valid;
	logic [31:0] res_value;
	logic        res_present;
	logic        res_row;
	logic        advance;

	logic        out_valid_q;
	logic [31:0] value_q;
	logic        present_q;
	logic        row_q;

	assign cfg_ready = 1'b1;

	always_comb begin
		in_quotes_d     = in_quotes_q;
		quote_pending_d = 1'b0;
		swallow_lf_d    = 1'b0;
		field_d         = field_q;
		res_valid       = 1'b0;
		res_value       = 32'd0;
		res_present     = 1'b0;
		res_row         = 1'b0;
		if (eoi_s1) begin
			in_quotes_d = 1'b0;
			field_d     = csvip_pkg::FIELD_CLEAR;
			res_valid   = 1'b1;
			res_row     = 1'b1;
		end else if (swallow_lf_q && data_s1 == csvip_pkg::CH_LF) begin
			quote_pending_d = quote_pending_q;
		end else if (quote_pending_q && data_s1 == csvip_pkg::CH_QUOTE) begin
			field_d = csvip_pkg::feed_char(field_q, csvip_pkg::CH_QUOTE);
		end else if (in_quotes_q && !quote_pending_q) begin
			if (data_s1 == csvip_pkg::CH_QUOTE) begin
				quote_pending_d = 1'b1;
			end else begin
				field_d = csvip_pkg::feed_char(field_q, data_s1);
			end
		end else begin
			in_quotes_d = 1'b0;
			if (data_s1 == csvip_pkg::CH_QUOTE) begin
				in_quotes_d = 1'b1;
			end else if (data_s1 == delim_q) begin
				res_valid   = 1'b1;
				res_value   = csvip_pkg::field_result(field_q);
				res_present = 1'b1;
				field_d     = csvip_pkg::FIELD_CLEAR;
			end else if (data_s1 == csvip_pkg::CH_CR || data_s1 == csvip_pkg::CH_LF) begin
				res_valid    = 1'b1;
				res_value    = csvip_pkg::field_result(field_q);
				res_present  = 1'b1;
				res_row      = 1'b1;
				field_d      = csvip_pkg::FIELD_CLEAR;
				swallow_lf_d = 1'b1;
			end else begin
				field_d = csvip_pkg::feed_char(field_q, data_s1);
			end
		end
	end

	assign advance  = valid_s1 && (!res_valid || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q <= csvip_pkg::DELIM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			delim_q <= delimiter_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= data_byte;
			eoi_s1  <= end_of_input;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_quotes_q     <= 1'b0;
			quote_pending_q <= 1'b0;
			swallow_lf_q    <= 1'b0;
			field_q         <= csvip_pkg::FIELD_CLEAR;
		end else if (advance) begin
			in_quotes_q     <= in_quotes_d;
			quote_pending_q <= quote_pending_d;
			swallow_lf_q    <= swallow_lf_d;
			field_q         <= field_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			value_q   <= res_value;
			present_q <= res_present;
			row_q     <= res_row;
		end
	end

	assign out_valid     = out_valid_q;
	assign field_value   = value_q;
	assign field_present = present_q;
	assign row_end       = row_q;

`ifndef SYNTHESIS
	// an item without a field is always a row end and carries zero
	a_empty_is_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !field_present |-> row_end && field_value == 32'sd0)
		else $error("empty item without row end or with nonzero value");

	a_pending_in_quotes: assert property (@(posedge clk) disable iff (!arst_n)
		quote_pending_q |-> in_quotes_q)
		else $error("quote pending outside quoted text");

	a_eoi_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && eoi_s1 |=> !in_quotes_q && !quote_pending_q && !swallow_lf_q
			&& field_q.phase == csvip_pkg::PH_LEAD)
		else $error("end of input did not clear parse state");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled with empty output register");

	a_clear_after_field: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res_present |=> field_q.acc == 32'd0 && !field_q.ovf)
		else $error("field state not cleared after result");
`endif

endmodule
